### rtl/sbde_pkg.sv
// ----------------------------------------------------------------------------
// Split-band de-esser package
// Shared types, fixed-point constants and register indices for the de-esser.
// ----------------------------------------------------------------------------
package sbde_pkg;

   typedef logic signed [23:0] sample_type;
   typedef logic signed [23:0] coef_type;
   typedef logic signed [15:0] db_type;

   localparam int SAMPLE_RATE = 48000;

   // Register indices on the configuration port.
   localparam logic [2:0] REG_COEF_B0    = 3'd0;
   localparam logic [2:0] REG_COEF_B1    = 3'd1;
   localparam logic [2:0] REG_COEF_B2    = 3'd2;
   localparam logic [2:0] REG_COEF_A1    = 3'd3;
   localparam logic [2:0] REG_COEF_A2    = 3'd4;
   localparam logic [2:0] REG_THRESHOLD  = 3'd5;
   localparam logic [2:0] REG_REDUCTION  = 3'd6;
   localparam logic [2:0] REG_ACTIVE_CH  = 3'd7;

   localparam logic signed [14:0] THRESHOLD_RESET = -15'sd5120;
   localparam logic signed [14:0] REDUCTION_RESET = -15'sd1536;
   localparam logic [1:0]         ACTIVE_RESET    = 2'd2;
   localparam logic [1:0]         MAX_CHANNELS    = 2'd2;

   localparam db_type DB_FLOOR = -16'sd30720;

   // Multiplier constants at the multiplier operand width, then unity and log2 full scale.
   localparam logic signed [33:0] DB_SCALE_Q16        = 34'sd394566;
   localparam logic signed [33:0] LOG2_10_OVER_20_Q16 = 34'sd10885;
   localparam logic signed [33:0] LN2_Q32             = 34'sd2977044472;
   localparam logic [32:0]        ONE_Q32             = 33'h1_0000_0000;
   localparam logic signed [22:0] LOG2_FULL_SCALE     = 23'sd1507328;

   // Time constants as Q32 exponents: 2000/fs for attack, 50/fs for release.
   localparam logic [63:0] X_ATTACK  = (64'd2000 << 32) / 64'(SAMPLE_RATE);
   localparam logic [63:0] X_RELEASE = (64'd50 << 32) / 64'(SAMPLE_RATE);

   localparam int unsigned EXP_TERMS = 14;

   // Uses of the shared exponential series.
   localparam logic [1:0] EXP_ATTACK  = 2'd0;
   localparam logic [1:0] EXP_RELEASE = 2'd1;
   localparam logic [1:0] EXP_GAIN    = 2'd2;

endpackage

### rtl/sbde_if.sv
// ----------------------------------------------------------------------------
// Split-band de-esser channels
// Valid/ready interfaces for the frame input and the processed frame output.
// ----------------------------------------------------------------------------
interface sbde_req_if;
   logic                 valid;
   logic                 ready;
   sbde_pkg::sample_type sample_ch0;
   sbde_pkg::sample_type sample_ch1;
   logic                 last_in_block;

   modport source (output valid, output sample_ch0, output sample_ch1,
                   output last_in_block, input ready);
   modport sink   (input valid, input sample_ch0, input sample_ch1,
                   input last_in_block, output ready);
endinterface

interface sbde_rsp_if;
   logic                 valid;
   logic                 ready;
   sbde_pkg::sample_type out_ch0;
   sbde_pkg::sample_type out_ch1;
   logic                 last_in_block_res;

   modport source (output valid, output out_ch0, output out_ch1,
                   output last_in_block_res, input ready);
   modport sink   (input valid, input out_ch0, input out_ch1,
                   input last_in_block_res, output ready);
endinterface

### rtl/split_band_de_esser.sv
// ----------------------------------------------------------------------------
// Split-band de-esser
// Detection bandpass, dB envelope follower, gain computer and band reduction
// on one shared multiplier under a small sequencer.
// ----------------------------------------------------------------------------
// One beat on req_chan carries a stereo frame; one beat on rsp_chan returns
// the processed frame in the same order. All multiplication runs through a
// single 34 by 34 bit multiplier with a registered product, stepped by a
// sequencer, so the block takes one frame at a time and drops ready until the
// frame's result is in the output register. Each biquad runs tap by tap for
// each channel; the level conversion normalises the peak and then squares
// repeatedly; and only when the envelope is above the threshold, the gain
// uses a 14-term exponential series whose division by the term number is
// done by a restoring divider at one bit per cycle. After reset the same
// series computes the attack and release coefficients; no frame is taken
// until then, while configuration writes are accepted at all times. With
// zero active channels a frame passes through unchanged.
// ----------------------------------------------------------------------------
module split_band_de_esser (
   input  logic              clock,
   input  logic              reset,
   sbde_req_if.sink          req_chan,
   sbde_rsp_if.source        rsp_chan,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [23:0]       csr_wdata
);

   // Sequencer states.
   localparam logic [4:0] S_IDLE     = 5'd0;
   localparam logic [4:0] S_BQ_MUL   = 5'd1;
   localparam logic [4:0] S_BQ_ACC   = 5'd2;
   localparam logic [4:0] S_BQ_END   = 5'd3;
   localparam logic [4:0] S_LOG_NORM = 5'd4;
   localparam logic [4:0] S_LOG_SQ   = 5'd5;
   localparam logic [4:0] S_LOG_CHK  = 5'd6;
   localparam logic [4:0] S_DB_MUL   = 5'd7;
   localparam logic [4:0] S_DB_ACC   = 5'd8;
   localparam logic [4:0] S_ENV_MUL  = 5'd9;
   localparam logic [4:0] S_ENV_ACC  = 5'd10;
   localparam logic [4:0] S_THR      = 5'd11;
   localparam logic [4:0] S_GP_MUL   = 5'd12;
   localparam logic [4:0] S_GF_MUL   = 5'd13;
   localparam logic [4:0] S_GF_DONE  = 5'd14;
   localparam logic [4:0] S_EXP_MUL  = 5'd15;
   localparam logic [4:0] S_EXP_LOAD = 5'd16;
   localparam logic [4:0] S_EXP_DIV  = 5'd17;
   localparam logic [4:0] S_EXP_ACC  = 5'd18;
   localparam logic [4:0] S_EXP_RET  = 5'd19;
   localparam logic [4:0] S_OUT_MUL  = 5'd20;
   localparam logic [4:0] S_OUT_ACC  = 5'd21;
   localparam logic [4:0] S_DONE     = 5'd22;

   // Saturate a wide signed value to the sample range.
   function automatic sbde_pkg::sample_type sat_sample(input logic signed [51:0] v);
      if (v > 52'sd8388607) begin
         return 24'sh7FFFFF;
      end else if (v < -52'sd8388608) begin
         return 24'sh800000;
      end
      return v[23:0];
   endfunction

   // Sequencer and loop counters.
   logic [4:0]                state_ff, state_in;
   logic [2:0]                tap_ff, tap_in;
   logic                      chan_ff, chan_in;
   logic                      bank_ff, bank_in;
   logic [1:0]                nch_ff, nch_in;

   // Configuration.
   sbde_pkg::coef_type        coef_ff [5];
   sbde_pkg::coef_type        coef_in [5];
   logic signed [14:0]        thr_ff, thr_in;
   logic signed [14:0]        red_db_ff, red_db_in;
   logic [1:0]                act_ff, act_in;

   // Filter history: index is {bank, channel, slot}, slots x1, x2, y1, y2.
   sbde_pkg::sample_type      hist_ff [16];
   sbde_pkg::sample_type      hist_in [16];

   // Datapath.
   logic signed [33:0]        mul_a, mul_b;
   logic signed [67:0]        prod_ff, prod_in;
   logic signed [51:0]        acc_ff, acc_in;
   sbde_pkg::sample_type      s_ff [2];
   sbde_pkg::sample_type      s_in [2];
   sbde_pkg::sample_type      res_ff [2];
   sbde_pkg::sample_type      res_in [2];
   logic                      last_ff, last_in;
   logic [23:0]               peak_ff, peak_in;
   logic [23:0]               norm_ff, norm_in;
   logic [4:0]                cnt_ff, cnt_in;
   logic [32:0]               m_ff, m_in;
   logic [3:0]                iter_ff, iter_in;
   logic [15:0]               frac_ff, frac_in;
   logic [4:0]                e_ff, e_in;
   sbde_pkg::db_type          det_ff, det_in;
   sbde_pkg::db_type          env_ff, env_in;
   logic signed [16:0]        red_ff, red_in;
   logic [24:0]               alpha_att_ff, alpha_att_in;
   logic [24:0]               alpha_rel_ff, alpha_rel_in;
   logic [24:0]               gain_ff, gain_in;
   logic [7:0]                ip_ff, ip_in;
   logic [31:0]               y_ff, y_in;
   logic [32:0]               term_ff, term_in;
   logic signed [35:0]        sum_ff, sum_in;
   logic [3:0]                k_ff, k_in;
   logic [31:0]               divq_ff, divq_in;
   logic [3:0]                rem_ff, rem_in;
   logic [4:0]                dcnt_ff, dcnt_in;
   logic [1:0]                mode_ff, mode_in;
   sbde_pkg::sample_type      band_ff, band_in;

   // Output register.
   logic                      rsp_valid_ff, rsp_valid_in;
   sbde_pkg::sample_type      out0_ff, out0_in;
   sbde_pkg::sample_type      out1_ff, out1_in;
   logic                      out_last_ff, out_last_in;

   // Helper values.
   logic [1:0]                hsel;
   logic [3:0]                hbase;
   sbde_pkg::sample_type      hist_rd;
   sbde_pkg::sample_type      cur_s;
   logic                      last_ch;
   logic signed [51:0]        bq_rnd;
   sbde_pkg::sample_type      bq_y;
   logic signed [24:0]        bq_yext;
   logic [23:0]               bq_abs;
   logic [23:0]               peak_new;
   logic [32:0]               log_mm;
   logic signed [22:0]        l_val;
   logic signed [67:0]        round24;
   sbde_pkg::db_type          db_val;
   logic signed [16:0]        env_diff;
   logic signed [16:0]        excess;
   logic signed [16:0]        maxred;
   logic [4:0]                div_r2;
   logic                      div_ge;
   logic [32:0]               exp_val;
   logic [24:0]               alpha_val;
   logic [24:0]               g_round;
   logic [24:0]               g_shift;
   logic signed [51:0]        out_sum;
   logic                      rsp_load;

   assign hsel    = 2'(tap_ff - 3'd1);
   assign hbase   = {bank_ff, chan_ff, 2'b00};
   assign hist_rd = hist_ff[{bank_ff, chan_ff, hsel}];
   assign cur_s   = s_ff[chan_ff];
   assign last_ch = ({1'b0, chan_ff} == 2'(nch_ff - 2'd1));

   // Biquad output: round half up at 22 fractional bits, then saturate.
   assign bq_rnd  = (acc_ff + 52'sd2097152) >>> 22;
   assign bq_y    = sat_sample(bq_rnd);
   assign bq_yext = 25'(bq_y);
   assign bq_abs  = bq_yext[24] ? 24'(-bq_yext) : 24'(bq_yext);
   assign peak_new = (bq_abs > peak_ff) ? bq_abs : peak_ff;

   // Repeated squaring keeps the mantissa in Q30.
   assign log_mm  = prod_ff[62:30];
   assign l_val   = $signed({2'b00, e_ff, frac_ff}) - sbde_pkg::LOG2_FULL_SCALE;

   // Shared rounding at 24 fractional bits for dB, envelope and band gain.
   assign round24 = (prod_ff + 68'sd8388608) >>> 24;
   assign db_val  = (round24 < -68'sd30720) ? sbde_pkg::DB_FLOOR : round24[15:0];

   assign env_diff = 17'(det_ff) - 17'(env_ff);
   assign excess   = 17'(env_ff) - 17'(thr_ff);
   assign maxred   = (red_db_ff > 15'sd0) ? 17'sd0 : -17'(red_db_ff);

   // Restoring division by the term number, one quotient bit per cycle.
   assign div_r2 = {rem_ff, divq_ff[31]};
   assign div_ge = (div_r2 >= {1'b0, k_ff});

   assign exp_val = (sum_ff < 36'sd0) ? 33'd0 :
                    (sum_ff > $signed({3'b000, sbde_pkg::ONE_Q32})) ? sbde_pkg::ONE_Q32 :
                    sum_ff[32:0];
   assign alpha_val = 25'((34'(sbde_pkg::ONE_Q32 - exp_val) + 34'd128) >> 8);
   assign g_round   = 25'((34'(exp_val) + 34'd128) >> 8);
   assign g_shift   = (ip_ff >= 8'd25) ? 25'd0 : (g_round >> ip_ff);

   assign out_sum = 52'(cur_s) - 52'(band_ff) + 52'(round24);

   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_chan.ready);

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a = 34'sd0;
      mul_b = 34'sd0;
      unique case (state_ff)
         S_BQ_MUL: begin
            mul_a = 34'(coef_ff[tap_ff]);
            mul_b = (tap_ff == 3'd0) ? 34'(cur_s) : 34'(hist_rd);
         end
         S_LOG_SQ: begin
            mul_a = $signed({1'b0, m_ff});
            mul_b = $signed({1'b0, m_ff});
         end
         S_DB_MUL: begin
            mul_a = 34'(l_val);
            mul_b = sbde_pkg::DB_SCALE_Q16;
         end
         S_ENV_MUL: begin
            mul_a = 34'(env_diff);
            mul_b = $signed({9'd0, (det_ff > env_ff) ? alpha_att_ff : alpha_rel_ff});
         end
         S_GP_MUL: begin
            mul_a = 34'(red_ff);
            mul_b = sbde_pkg::LOG2_10_OVER_20_Q16;
         end
         S_GF_MUL: begin
            mul_a = $signed({10'd0, prod_ff[23:0]});
            mul_b = sbde_pkg::LN2_Q32;
         end
         S_EXP_MUL: begin
            mul_a = $signed({1'b0, term_ff});
            mul_b = $signed({2'b00, y_ff});
         end
         S_OUT_MUL: begin
            mul_a = 34'(band_ff);
            mul_b = $signed({9'd0, gain_ff});
         end
         default: begin
            mul_a = 34'sd0;
            mul_b = 34'sd0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // Sequencer and datapath next state.
   always_comb begin
      state_in     = state_ff;
      tap_in       = tap_ff;
      chan_in      = chan_ff;
      bank_in      = bank_ff;
      nch_in       = nch_ff;
      coef_in      = coef_ff;
      thr_in       = thr_ff;
      red_db_in    = red_db_ff;
      act_in       = act_ff;
      hist_in      = hist_ff;
      acc_in       = acc_ff;
      s_in         = s_ff;
      res_in       = res_ff;
      last_in      = last_ff;
      peak_in      = peak_ff;
      norm_in      = norm_ff;
      cnt_in       = cnt_ff;
      m_in         = m_ff;
      iter_in      = iter_ff;
      frac_in      = frac_ff;
      e_in         = e_ff;
      det_in       = det_ff;
      env_in       = env_ff;
      red_in       = red_ff;
      alpha_att_in = alpha_att_ff;
      alpha_rel_in = alpha_rel_ff;
      gain_in      = gain_ff;
      ip_in        = ip_ff;
      y_in         = y_ff;
      term_in      = term_ff;
      sum_in       = sum_ff;
      k_in         = k_ff;
      divq_in      = divq_ff;
      rem_in       = rem_ff;
      dcnt_in      = dcnt_ff;
      mode_in      = mode_ff;
      band_in      = band_ff;

      if (csr_we) begin
         unique case (csr_index)
            sbde_pkg::REG_COEF_B0:   coef_in[0] = csr_wdata;
            sbde_pkg::REG_COEF_B1:   coef_in[1] = csr_wdata;
            sbde_pkg::REG_COEF_B2:   coef_in[2] = csr_wdata;
            sbde_pkg::REG_COEF_A1:   coef_in[3] = csr_wdata;
            sbde_pkg::REG_COEF_A2:   coef_in[4] = csr_wdata;
            sbde_pkg::REG_THRESHOLD: thr_in     = csr_wdata[14:0];
            sbde_pkg::REG_REDUCTION: red_db_in  = csr_wdata[14:0];
            sbde_pkg::REG_ACTIVE_CH: act_in     = csr_wdata[1:0];
            default:                 act_in     = act_ff;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               s_in[0]   = req_chan.sample_ch0;
               s_in[1]   = req_chan.sample_ch1;
               res_in[0] = req_chan.sample_ch0;
               res_in[1] = req_chan.sample_ch1;
               last_in   = req_chan.last_in_block;
               nch_in    = (act_ff > sbde_pkg::MAX_CHANNELS) ? sbde_pkg::MAX_CHANNELS
                                                            : act_ff;
               bank_in   = 1'b0;
               chan_in   = 1'b0;
               tap_in    = 3'd0;
               peak_in   = 24'd0;
               state_in  = (act_ff == 2'd0) ? S_DONE : S_BQ_MUL;
            end
         end
         S_BQ_MUL: begin
            state_in = S_BQ_ACC;
         end
         S_BQ_ACC: begin
            // Feedback taps are subtracted.
            if (tap_ff >= 3'd3) begin
               acc_in = ((tap_ff == 3'd0) ? 52'sd0 : acc_ff) - prod_ff[51:0];
            end else begin
               acc_in = ((tap_ff == 3'd0) ? 52'sd0 : acc_ff) + prod_ff[51:0];
            end
            if (tap_ff == 3'd4) begin
               state_in = S_BQ_END;
            end else begin
               tap_in   = tap_ff + 3'd1;
               state_in = S_BQ_MUL;
            end
         end
         S_BQ_END: begin
            hist_in[hbase + 4'd1] = hist_ff[hbase];
            hist_in[hbase]        = cur_s;
            hist_in[hbase + 4'd3] = hist_ff[hbase + 4'd2];
            hist_in[hbase + 4'd2] = bq_y;
            tap_in = 3'd0;
            if (!bank_ff) begin
               peak_in = peak_new;
               if (last_ch) begin
                  norm_in = peak_new;
                  cnt_in  = 5'd0;
                  if (peak_new == 24'd0) begin
                     det_in   = sbde_pkg::DB_FLOOR;
                     state_in = S_ENV_MUL;
                  end else begin
                     state_in = S_LOG_NORM;
                  end
               end else begin
                  chan_in  = 1'b1;
                  state_in = S_BQ_MUL;
               end
            end else begin
               band_in  = bq_y;
               state_in = S_OUT_MUL;
            end
         end
         S_LOG_NORM: begin
            if (norm_ff[23]) begin
               m_in     = {2'b00, norm_ff, 7'd0};
               e_in     = 5'(5'd23 - cnt_ff);
               iter_in  = 4'd0;
               frac_in  = 16'd0;
               state_in = S_LOG_SQ;
            end else begin
               norm_in = {norm_ff[22:0], 1'b0};
               cnt_in  = cnt_ff + 5'd1;
            end
         end
         S_LOG_SQ: begin
            state_in = S_LOG_CHK;
         end
         S_LOG_CHK: begin
            if (log_mm[31]) begin
               m_in = {1'b0, log_mm[32:1]};
               frac_in[4'd15 - iter_ff] = 1'b1;
            end else begin
               m_in = log_mm;
            end
            if (iter_ff == 4'd15) begin
               state_in = S_DB_MUL;
            end else begin
               iter_in  = iter_ff + 4'd1;
               state_in = S_LOG_SQ;
            end
         end
         S_DB_MUL: begin
            state_in = S_DB_ACC;
         end
         S_DB_ACC: begin
            det_in   = db_val;
            state_in = S_ENV_MUL;
         end
         S_ENV_MUL: begin
            state_in = S_ENV_ACC;
         end
         S_ENV_ACC: begin
            env_in   = env_ff + round24[15:0];
            state_in = S_THR;
         end
         S_THR: begin
            if (env_ff > 16'(thr_ff)) begin
               red_in   = (excess < maxred) ? excess : maxred;
               state_in = S_GP_MUL;
            end else begin
               gain_in  = 25'h100_0000;
               bank_in  = 1'b1;
               chan_in  = 1'b0;
               tap_in   = 3'd0;
               state_in = S_BQ_MUL;
            end
         end
         S_GP_MUL: begin
            state_in = S_GF_MUL;
         end
         S_GF_MUL: begin
            ip_in    = prod_ff[31:24];
            state_in = S_GF_DONE;
         end
         S_GF_DONE: begin
            y_in     = prod_ff[55:24];
            term_in  = sbde_pkg::ONE_Q32;
            sum_in   = 36'(sbde_pkg::ONE_Q32);
            k_in     = 4'd1;
            mode_in  = sbde_pkg::EXP_GAIN;
            state_in = S_EXP_MUL;
         end
         S_EXP_MUL: begin
            state_in = S_EXP_LOAD;
         end
         S_EXP_LOAD: begin
            divq_in  = prod_ff[63:32];
            rem_in   = 4'd0;
            dcnt_in  = 5'd0;
            state_in = S_EXP_DIV;
         end
         S_EXP_DIV: begin
            rem_in  = div_ge ? 4'(div_r2 - {1'b0, k_ff}) : div_r2[3:0];
            divq_in = {divq_ff[30:0], div_ge};
            dcnt_in = dcnt_ff + 5'd1;
            if (dcnt_ff == 5'd31) begin
               state_in = S_EXP_ACC;
            end
         end
         S_EXP_ACC: begin
            term_in = {1'b0, divq_ff};
            if (k_ff[0]) begin
               sum_in = sum_ff - $signed({4'd0, divq_ff});
            end else begin
               sum_in = sum_ff + $signed({4'd0, divq_ff});
            end
            if (k_ff == 4'(sbde_pkg::EXP_TERMS)) begin
               state_in = S_EXP_RET;
            end else begin
               k_in     = k_ff + 4'd1;
               state_in = S_EXP_MUL;
            end
         end
         S_EXP_RET: begin
            unique case (mode_ff)
               sbde_pkg::EXP_ATTACK: begin
                  alpha_att_in = alpha_val;
                  y_in         = sbde_pkg::X_RELEASE[31:0];
                  term_in      = sbde_pkg::ONE_Q32;
                  sum_in       = 36'(sbde_pkg::ONE_Q32);
                  k_in         = 4'd1;
                  mode_in      = sbde_pkg::EXP_RELEASE;
                  state_in     = S_EXP_MUL;
               end
               sbde_pkg::EXP_RELEASE: begin
                  alpha_rel_in = alpha_val;
                  state_in     = S_IDLE;
               end
               default: begin
                  gain_in  = g_shift;
                  bank_in  = 1'b1;
                  chan_in  = 1'b0;
                  tap_in   = 3'd0;
                  state_in = S_BQ_MUL;
               end
            endcase
         end
         S_OUT_MUL: begin
            state_in = S_OUT_ACC;
         end
         S_OUT_ACC: begin
            res_in[chan_ff] = sat_sample(out_sum);
            if (last_ch) begin
               state_in = S_DONE;
            end else begin
               chan_in  = 1'b1;
               tap_in   = 3'd0;
               state_in = S_BQ_MUL;
            end
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register: holds a finished frame until the sink takes it.
   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && !rsp_chan.ready);
   assign out0_in      = rsp_load ? res_ff[0] : out0_ff;
   assign out1_in      = rsp_load ? res_ff[1] : out1_ff;
   assign out_last_in  = rsp_load ? last_ff : out_last_ff;

   assign req_chan.ready             = (state_ff == S_IDLE);
   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.out_ch0           = out0_ff;
   assign rsp_chan.out_ch1           = out1_ff;
   assign rsp_chan.last_in_block_res = out_last_ff;

   // Control state, configuration and filter state.
   always_ff @(posedge clock) begin
      if (reset) begin
         // Reset starts the attack coefficient computation.
         state_ff     <= S_EXP_MUL;
         tap_ff       <= 3'd0;
         chan_ff      <= 1'b0;
         bank_ff      <= 1'b0;
         nch_ff       <= 2'd0;
         coef_ff      <= '{default: 24'sd0};
         thr_ff       <= sbde_pkg::THRESHOLD_RESET;
         red_db_ff    <= sbde_pkg::REDUCTION_RESET;
         act_ff       <= sbde_pkg::ACTIVE_RESET;
         hist_ff      <= '{default: 24'sd0};
         env_ff       <= sbde_pkg::DB_FLOOR;
         y_ff         <= sbde_pkg::X_ATTACK[31:0];
         term_ff      <= sbde_pkg::ONE_Q32;
         sum_ff       <= 36'(sbde_pkg::ONE_Q32);
         k_ff         <= 4'd1;
         dcnt_ff      <= 5'd0;
         cnt_ff       <= 5'd0;
         iter_ff      <= 4'd0;
         mode_ff      <= sbde_pkg::EXP_ATTACK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tap_ff       <= tap_in;
         chan_ff      <= chan_in;
         bank_ff      <= bank_in;
         nch_ff       <= nch_in;
         coef_ff      <= coef_in;
         thr_ff       <= thr_in;
         red_db_ff    <= red_db_in;
         act_ff       <= act_in;
         hist_ff      <= hist_in;
         env_ff       <= env_in;
         y_ff         <= y_in;
         term_ff      <= term_in;
         sum_ff       <= sum_in;
         k_ff         <= k_in;
         dcnt_ff      <= dcnt_in;
         cnt_ff       <= cnt_in;
         iter_ff      <= iter_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      s_ff         <= s_in;
      res_ff       <= res_in;
      last_ff      <= last_in;
      peak_ff      <= peak_in;
      norm_ff      <= norm_in;
      m_ff         <= m_in;
      frac_ff      <= frac_in;
      e_ff         <= e_in;
      det_ff       <= det_in;
      red_ff       <= red_in;
      alpha_att_ff <= alpha_att_in;
      alpha_rel_ff <= alpha_rel_in;
      gain_ff      <= gain_in;
      ip_ff        <= ip_in;
      divq_ff      <= divq_in;
      rem_ff       <= rem_in;
      band_ff      <= band_in;
      out0_ff      <= out0_in;
      out1_ff      <= out1_in;
      out_last_ff  <= out_last_in;
   end

endmodule
